[sv/llat_pkg.sv]
// Shared types, codes and helper functions for the life-like automaton core.
// Used by llat_ctrl, llat_dpath and life_like_automaton_torus_core.
// No dependencies.
package llat_pkg;

  // Default grid size; both dimensions must be powers of two.
  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  // Channel widths.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int LIVE_W      = 13;
  localparam int CFG_IDX_W   = 1;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 1'd1;

  // Register reset values.
  localparam logic [7:0] BIRTH_RST   = 8'd8;
  localparam logic [7:0] SURVIVE_RST = 8'd12;

  // Source of the cell bit in a result.
  localparam logic [1:0] CELL_ZERO = 2'd0;
  localparam logic [1:0] CELL_ROW  = 2'd1;
  localparam logic [1:0] CELL_WVAL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       rd_en;     // read one grid row
    logic       shift;     // move the row window down by one row
    logic       first_ld;  // save the original first row
    logic       gen_wr;    // write the next-generation row
    logic       use_first; // bottom neighbor row is the saved first row
    logic       poke_wr;   // write the fetched row with one cell changed
    logic       cell_ld;   // load the result cell bit
    logic [1:0] cell_sel;  // source of the result cell bit
    logic       out_ld;    // load the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy; // output register holds a result that is not taken now
  } ctrl_sts_t;

  // Number of set bits in one byte.
  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

[sv/llat_ctrl.sv]
// Controller state machine of the life-like automaton core.
// Sequences row reads, writes and generation sweeps; depends on llat_pkg.
module llat_ctrl #(
  parameter int GRID_W = llat_pkg::GRID_W_DEF,
  parameter int GRID_H = llat_pkg::GRID_H_DEF,
  localparam int XW = $clog2(GRID_W),
  localparam int AW = $clog2(GRID_H)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input item fields.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [5:0]            in_cell_x,
  input  logic [5:0]            in_cell_y,
  input  logic                  in_write_value,
  input  logic [7:0]            in_generation_count,
  // Datapath control.
  output llat_pkg::ctrl_cmd_t   cmd,
  input  llat_pkg::ctrl_sts_t   sts,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output logic [XW-1:0]         cell_x,
  output logic                  write_value
);

  localparam int SW = $clog2(GRID_H + 3);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_GEN   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [7:0]    gen_left_r, gen_left_nxt;
  logic [1:0]    act_r, act_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [AW-1:0] y_r, y_nxt;
  logic          wval_r, wval_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cell_x      = x_r;
  assign write_value = wval_r;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    gen_left_nxt = gen_left_r;
    act_nxt      = act_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    wval_nxt     = wval_r;
    cmd          = '0;
    rd_addr      = '0;
    wr_addr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          x_nxt        = XW'(in_cell_x % GRID_W);
          y_nxt        = AW'(in_cell_y % GRID_H);
          wval_nxt     = in_write_value;
          gen_left_nxt = in_generation_count;
          step_nxt     = '0;
          cmd.cell_ld  = 1'b1;
          cmd.cell_sel = llat_pkg::CELL_ZERO;
          if (in_action == llat_pkg::ACT_WRITE || in_action == llat_pkg::ACT_READ) begin
            state_nxt = S_FETCH;
          end else if (in_action == llat_pkg::ACT_ADVANCE && in_generation_count != 8'd0) begin
            state_nxt = S_GEN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        rd_addr   = y_r;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.cell_ld = 1'b1;
        if (act_r == llat_pkg::ACT_WRITE) begin
          cmd.poke_wr  = 1'b1;
          wr_addr      = y_r;
          cmd.cell_sel = llat_pkg::CELL_WVAL;
        end else begin
          cmd.cell_sel = llat_pkg::CELL_ROW;
        end
        step_nxt  = '0;
        state_nxt = S_DRAIN;
      end
      S_GEN: begin
        // Reads: last row first, then rows top to bottom.
        if (step_r <= SW'(GRID_H)) begin
          cmd.rd_en = 1'b1;
          rd_addr   = (step_r == '0) ? AW'(GRID_H - 1) : AW'(step_r - SW'(1));
        end
        if (step_r >= SW'(1) && step_r <= SW'(GRID_H + 1)) begin
          cmd.shift = 1'b1;
        end
        if (step_r == SW'(2)) begin
          cmd.first_ld = 1'b1;
        end
        // Writes: row y once its lower neighbor has been fetched.
        if (step_r >= SW'(3)) begin
          cmd.gen_wr = 1'b1;
          wr_addr    = AW'(step_r - SW'(3));
        end
        if (step_r == SW'(GRID_H + 2)) begin
          cmd.use_first = 1'b1;
          step_nxt      = '0;
          if (gen_left_r == 8'd1) begin
            state_nxt = S_DRAIN;
          end else begin
            gen_left_nxt = gen_left_r - 8'd1;
          end
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_DRAIN: begin
        // Let the live-count pipeline settle.
        if (step_r == SW'(1)) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      gen_left_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      gen_left_r <= gen_left_nxt;
    end
  end

  // Latched item fields.
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    wval_r <= wval_nxt;
  end

endmodule

[sv/llat_dpath.sv]
// Datapath of the life-like automaton core: grid row memory, row window,
// cell update lanes, live-count pipeline, rule registers and output register.
// Depends on llat_pkg.
module llat_dpath #(
  parameter int GRID_W = llat_pkg::GRID_W_DEF,
  parameter int GRID_H = llat_pkg::GRID_H_DEF,
  localparam int XW = $clog2(GRID_W),
  localparam int AW = $clog2(GRID_H)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  llat_pkg::ctrl_cmd_t                  cmd,
  output llat_pkg::ctrl_sts_t                  sts,
  input  logic [AW-1:0]                        rd_addr,
  input  logic [AW-1:0]                        wr_addr,
  input  logic [XW-1:0]                        cell_x,
  input  logic                                 write_value,
  input  logic                                 cfg_valid,
  input  logic [llat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                           cfg_data,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [llat_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int CNT_W = $clog2(GRID_W * GRID_H + 1);
  localparam int LANES = (GRID_W + 7) / 8;

  // Grid memory; a row never written reads as all dead.
  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_H-1:0] row_valid_r;
  logic [GRID_W-1:0] rd_data_r;
  logic              rd_valid_r;
  logic [GRID_W-1:0] rd_row;

  // Row window and saved first row.
  logic [GRID_W-1:0] prev_r, cur_r, first_r;
  logic [GRID_W-1:0] below;
  logic [GRID_W-1:0] gen_row;
  logic [GRID_W-1:0] poke_row;
  logic [GRID_W-1:0] wr_row;
  logic              wr_en;

  // Rule registers.
  logic [7:0] birth_r, survive_r;

  // Live-count pipeline.
  logic                  cnt_v1_r;
  logic [GRID_W-1:0]     cnt_new_r, cnt_old_r;
  logic                  cnt_v2_r;
  logic [3:0]            lane_new_r [LANES];
  logic [3:0]            lane_old_r [LANES];
  logic [LANES*8-1:0]    new_pad, old_pad;
  logic [CNT_W-1:0]      sum_new, sum_old;
  logic [CNT_W-1:0]      live_r;

  // Result.
  logic       cell_r;
  logic       out_valid_r;
  logic [llat_pkg::OUT_TDATA_W-1:0] out_data_r;

  assign rd_row = rd_valid_r ? rd_data_r : '0;
  assign below  = cmd.use_first ? first_r : rd_row;

  // One update lane per column, neighbors wrap around the grid.
  for (genvar x = 0; x < GRID_W; x++) begin : g_lane
    localparam int L = (x + GRID_W - 1) % GRID_W;
    localparam int R = (x + 1) % GRID_W;
    logic [7:0] nbr;
    logic [3:0] n;
    assign nbr = {prev_r[L], prev_r[x], prev_r[R], cur_r[L], cur_r[R],
                  below[L], below[x], below[R]};
    assign n   = llat_pkg::popcount8(nbr);
    assign gen_row[x] = n[3] ? 1'b0 : (cur_r[x] ? survive_r[n[2:0]] : birth_r[n[2:0]]);
  end

  // Fetched row with the addressed cell replaced.
  always_comb begin
    poke_row         = rd_row;
    poke_row[cell_x] = write_value;
  end

  assign wr_en  = cmd.gen_wr | cmd.poke_wr;
  assign wr_row = cmd.gen_wr ? gen_row : poke_row;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
    end
  end

  // Row window for the generation sweep.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      prev_r <= cur_r;
      cur_r  <= rd_row;
    end
    if (cmd.first_ld) begin
      first_r <= rd_row;
    end
  end

  // Rule registers written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      birth_r   <= llat_pkg::BIRTH_RST;
      survive_r <= llat_pkg::SURVIVE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        llat_pkg::REG_BIRTH:   birth_r   <= cfg_data;
        llat_pkg::REG_SURVIVE: survive_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Live count stage 1: capture the written row and its old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_new_r <= wr_row;
      cnt_old_r <= cmd.gen_wr ? cur_r : rd_row;
    end
  end

  // Live count stage 2: per-byte population counts.
  assign new_pad = (LANES*8)'(cnt_new_r);
  assign old_pad = (LANES*8)'(cnt_old_r);

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      lane_new_r[i] <= llat_pkg::popcount8(new_pad[i*8 +: 8]);
      lane_old_r[i] <= llat_pkg::popcount8(old_pad[i*8 +: 8]);
    end
  end

  // Live count stage 3: add the row difference to the total.
  always_comb begin
    sum_new = '0;
    sum_old = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_new = sum_new + CNT_W'(lane_new_r[i]);
      sum_old = sum_old + CNT_W'(lane_old_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_v1_r <= 1'b0;
      cnt_v2_r <= 1'b0;
      live_r   <= '0;
    end else begin
      cnt_v1_r <= wr_en;
      cnt_v2_r <= cnt_v1_r;
      if (cnt_v2_r) begin
        live_r <= live_r + sum_new - sum_old;
      end
    end
  end

  // Result cell bit.
  always_ff @(posedge clk) begin
    if (cmd.cell_ld) begin
      case (cmd.cell_sel)
        llat_pkg::CELL_ROW:  cell_r <= rd_row[cell_x];
        llat_pkg::CELL_WVAL: cell_r <= write_value;
        default:             cell_r <= 1'b0;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {2'b00, llat_pkg::LIVE_W'(live_r), cell_r};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.out_busy = out_valid_r & ~out_tready;

endmodule

[sv/life_like_automaton_torus_core.sv]
// Life-like cellular automaton on a toroidal grid: top level.
// Input, output and configuration channels; the grid is held in one row
// memory. Transactions on in_ write a cell, read a cell or advance the grid.
// Each accepted transaction yields exactly one out_ transaction carrying the
// cell bit (zero for an advance) and the number of live cells afterwards.
// A write or read passes the fetch, execute, drain and done states before
// out_tvalid; an unused action or a zero-generation advance goes straight to
// the done state, and an advance of g generations runs g row sweeps, then
// drain and done. The single memory read port fetches one row per cycle.
// Items are handled one at a time; in_tready is high only while the block
// is idle, from the cycle after a result is loaded, so a new item is taken
// only once the result of the previous item has been loaded.
// A stalled receiver keeps the result in the output register; the next
// result waits until that register is free, and the input stalls meanwhile.
// Rule registers on cfg_: index 0 birth mask, index 1 survive mask; cfg_ready
// is always high. Write them only while the block is idle.
// Reset (rst_n low, synchronous) kills every cell, clears the live count and
// loads the default rules (birth on 3, survive on 2 or 3).
// Depends on llat_pkg, llat_ctrl and llat_dpath.
module life_like_automaton_torus_core #(
  parameter int GRID_W = llat_pkg::GRID_W_DEF,
  parameter int GRID_H = llat_pkg::GRID_H_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // action[1:0], cell_x[7:2], cell_y[13:8], write_value[14],
  // generation_count[22:15], zero pad[23]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [llat_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cell_value[0], live_total[13:1], zero pad[15:14]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [llat_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration writes.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [llat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                          cfg_data
);

  localparam int XW = $clog2(GRID_W);
  localparam int AW = $clog2(GRID_H);

  llat_pkg::ctrl_cmd_t cmd;
  llat_pkg::ctrl_sts_t sts;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [XW-1:0]       cell_x;
  logic                write_value;

  assign cfg_ready = 1'b1;

  // Sequencer.
  llat_ctrl #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_tvalid),
    .in_ready            (in_tready),
    .in_action           (in_tdata[1:0]),
    .in_cell_x           (in_tdata[7:2]),
    .in_cell_y           (in_tdata[13:8]),
    .in_write_value      (in_tdata[14]),
    .in_generation_count (in_tdata[22:15]),
    .cmd                 (cmd),
    .sts                 (sts),
    .rd_addr             (rd_addr),
    .wr_addr             (wr_addr),
    .cell_x              (cell_x),
    .write_value         (write_value)
  );

  // Grid storage and update logic.
  llat_dpath #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .cell_x      (cell_x),
    .write_value (write_value),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

endmodule
